// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/psp_pkg.sv
// Shared constants, codes and types of the polygon support point core.
`timescale 1ns / 1ps

package psp_pkg;

  // Store capacity and derived widths
  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 16;
  localparam int SUM_W        = COORD_W + IDX_W;
  localparam int PROD_W       = 2 * COORD_W;
  localparam int DOT_W        = PROD_W + 1;
  localparam int SIDX_W       = 6;
  localparam int IDXX_W       = (IDX_W > SIDX_W) ? IDX_W : SIDX_W;
  localparam int DIV_STEP_W   = $clog2(SUM_W + 1);
  localparam int OP_W         = 2;
  localparam int STAT_W       = 2;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/core/polygon_support_point_core.sv
// Top level of the polygon support point core.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_ready): one request carries in_opcode, in_coord_x and
//   in_coord_y. Clear empties the vertex store, append stores one Q12.4 vertex,
//   query asks for the support point along the given direction.
//   Output channel (out_valid / out_ready): one result per query, none for clear,
//   append or unused opcodes. A result holds the support vertex, its store index,
//   the centroid and a status (ok, empty, appends dropped).
//   Clear and append keep the core in idle; it is ready again next cycle.
//   A query holds in_ready low until its result is loaded, which needs both the scan
//   and the centroid divisions finished: the scan reads one vertex per cycle from the
//   vertex RAM through a dot-product and compare pipeline of four stages. A shared
//   bit-serial divider computes the two centroid coordinates one after the other in
//   parallel with the scan. A query on an empty store skips both and goes straight
//   to the done state.
//   A finished result waits in the output register while the receiver stalls;
//   clear and append requests are still taken, a further query waits before its
//   result is loaded.
//   Reset (rst_n low, synchronous) empties the store and drops any pending result.

module polygon_support_point_core import psp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_W-1:0]           in_opcode,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_support_x,
  output logic signed [COORD_W-1:0] out_support_y,
  output logic [SIDX_W-1:0]         out_support_index,
  output logic signed [COORD_W-1:0] out_centre_x,
  output logic signed [COORD_W-1:0] out_centre_y,
  output logic [STAT_W-1:0]         out_status
);

  state_t state_r, state_nxt;

  // Store bookkeeping
  logic [CNT_W-1:0]          count_r;
  logic signed [SUM_W-1:0]   sum_x_r;
  logic signed [SUM_W-1:0]   sum_y_r;
  logic                      dropped_r;

  // Query context
  logic signed [COORD_W-1:0] dir_x_r;
  logic signed [COORD_W-1:0] dir_y_r;
  logic                      empty_r;
  logic [CNT_W-1:0]          issue_cnt_r;

  // Scan pipeline
  logic                      s1_v_r, s2_v_r, s3_v_r;
  logic [IDX_W-1:0]          s1_idx_r, s2_idx_r, s3_idx_r;
  logic signed [COORD_W-1:0] s2_x_r, s2_y_r, s3_x_r, s3_y_r;
  logic signed [PROD_W-1:0]  prod_x_r, prod_y_r;
  logic signed [DOT_W-1:0]   dot_r;

  // Best candidate so far
  logic signed [DOT_W-1:0]   best_dot_r;
  logic signed [COORD_W-1:0] best_x_r, best_y_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic [IDXX_W-1:0]         best_idx_ext;

  // Centroid divider control
  logic                      div_phase_y_r;
  logic                      div_fin_r;
  logic signed [COORD_W-1:0] centre_x_r, centre_y_r;
  logic                      div_start;
  logic                      div_done;
  logic signed [SUM_W-1:0]   div_dividend;
  logic signed [COORD_W-1:0] div_quotient;

  // Output register
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r, out_cx_r, out_cy_r;
  logic [SIDX_W-1:0]         out_idx_r;
  logic [STAT_W-1:0]         out_stat_r;

  // RAM ports and strobes
  logic                      in_fire;
  logic                      is_query, is_append, is_clear;
  logic                      append_ok;
  logic                      rd_en;
  logic                      scan_last;
  logic                      load_out;
  logic [2*COORD_W-1:0]      ram_q;
  logic signed [COORD_W-1:0] ram_x, ram_y;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_clear  = in_fire && (in_opcode == OP_CLEAR);
  assign is_append = in_fire && (in_opcode == OP_APPEND);
  assign is_query  = in_fire && (in_opcode == OP_QUERY);
  assign append_ok = (count_r < CNT_W'(MAX_VERTICES));
  assign scan_last = (issue_cnt_r == CNT_W'(count_r - CNT_W'(1)));
  assign ram_x     = $signed(ram_q[2*COORD_W-1:COORD_W]);
  assign ram_y     = $signed(ram_q[COORD_W-1:0]);

  psp_ram #(
    .WIDTH(2 * COORD_W),
    .DEPTH(MAX_VERTICES)
  ) u_vtx_ram (
    .clk    (clk),
    .wr_en  (is_append && append_ok),
    .wr_addr(count_r[IDX_W-1:0]),
    .wr_data({in_coord_x, in_coord_y}),
    .rd_en  (rd_en),
    .rd_addr(issue_cnt_r[IDX_W-1:0]),
    .rd_data(ram_q)
  );

  // Start x division on a query to a non-empty store, y division once x is done
  assign div_start    = (is_query && (count_r != '0)) || (div_done && !div_phase_y_r);
  assign div_dividend = (state_r == ST_IDLE) ? sum_x_r : sum_y_r;

  psp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (count_r),
    .done    (div_done),
    .quotient(div_quotient)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the sequencer and drive its strobes
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (is_query) begin
          state_nxt = (count_r == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r && !s3_v_r && div_fin_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Update store bookkeeping on clear and append requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      dropped_r <= 1'b0;
    end else if (is_clear) begin
      count_r   <= '0;
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      dropped_r <= 1'b0;
    end else if (is_append) begin
      if (append_ok) begin
        count_r <= count_r + CNT_W'(1);
        sum_x_r <= sum_x_r + SUM_W'(in_coord_x);
        sum_y_r <= sum_y_r + SUM_W'(in_coord_y);
      end else begin
        dropped_r <= 1'b1;
      end
    end
  end

  // Track scan issue and pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_cnt_r   <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      s3_v_r        <= 1'b0;
      empty_r       <= 1'b0;
      div_phase_y_r <= 1'b0;
      div_fin_r     <= 1'b0;
    end else begin
      s1_v_r <= rd_en;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (is_query) begin
        issue_cnt_r   <= '0;
        empty_r       <= (count_r == '0);
        div_phase_y_r <= 1'b0;
        div_fin_r     <= 1'b0;
      end else begin
        if (rd_en) begin
          issue_cnt_r <= issue_cnt_r + CNT_W'(1);
        end
        if (div_done) begin
          if (div_phase_y_r) begin
            div_fin_r <= 1'b1;
          end else begin
            div_phase_y_r <= 1'b1;
          end
        end
      end
    end
  end

  // Latch the direction, multiply, add and compare one vertex per stage, and store the centroid quotients
  always_ff @(posedge clk) begin
    if (is_query) begin
      dir_x_r <= in_coord_x;
      dir_y_r <= in_coord_y;
    end
    s1_idx_r <= issue_cnt_r[IDX_W-1:0];
    prod_x_r <= ram_x * dir_x_r;
    prod_y_r <= ram_y * dir_y_r;
    s2_idx_r <= s1_idx_r;
    s2_x_r   <= ram_x;
    s2_y_r   <= ram_y;
    dot_r    <= DOT_W'(prod_x_r) + DOT_W'(prod_y_r);
    s3_idx_r <= s2_idx_r;
    s3_x_r   <= s2_x_r;
    s3_y_r   <= s2_y_r;
    // Keep the first vertex, replace only on a strictly larger dot product
    if (s3_v_r && ((s3_idx_r == '0) || (dot_r > best_dot_r))) begin
      best_dot_r <= dot_r;
      best_x_r   <= s3_x_r;
      best_y_r   <= s3_y_r;
      best_idx_r <= s3_idx_r;
    end
    if (div_done) begin
      if (div_phase_y_r) begin
        centre_y_r <= div_quotient;
      end else begin
        centre_x_r <= div_quotient;
      end
    end
  end

  assign best_idx_ext = IDXX_W'(best_idx_r);

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (empty_r) begin
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_idx_r  <= '0;
        out_cx_r   <= '0;
        out_cy_r   <= '0;
        out_stat_r <= STAT_EMPTY;
      end else begin
        out_x_r    <= best_x_r;
        out_y_r    <= best_y_r;
        out_idx_r  <= best_idx_ext[SIDX_W-1:0];
        out_cx_r   <= centre_x_r;
        out_cy_r   <= centre_y_r;
        out_stat_r <= dropped_r ? STAT_DROPPED : STAT_OK;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_support_x     = out_x_r;
  assign out_support_y     = out_y_r;
  assign out_support_index = out_idx_r;
  assign out_centre_x      = out_cx_r;
  assign out_centre_y      = out_cy_r;
  assign out_status        = out_stat_r;

endmodule

// File: rtl/core/psp_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module psp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/psp_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module psp_div import psp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]          divisor,
  output logic                      done,
  output logic signed [COORD_W-1:0] quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic                  neg_r;
  logic [SUM_W-1:0]      shift_r;
  logic [CNT_W-1:0]      rem_r;
  logic [CNT_W-1:0]      div_r;
  logic [DIV_STEP_W-1:0] step_r;

  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        diff;
  logic                  ge;
  logic [SUM_W-1:0]      q_signed;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial    = {rem_r, shift_r[SUM_W-1]};
    diff     = trial - {1'b0, div_r};
    ge       = (trial >= {1'b0, div_r});
    q_signed = neg_r ? (~shift_r + SUM_W'(1)) : shift_r;
  end

  assign done     = done_r;
  assign quotient = q_signed[COORD_W-1:0];

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= DIV_STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - DIV_STEP_W'(1);
        if (step_r == DIV_STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load magnitude, then shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r   <= dividend[SUM_W-1];
      shift_r <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
      rem_r   <= '0;
      div_r   <= divisor;
    end else if (busy_r) begin
      shift_r <= {shift_r[SUM_W-2:0], ge};
      rem_r   <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

endmodule

// File: rtl/core/psp_chk.sv
// Port-level assertions for the polygon support point core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psp_chk import psp_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [OP_W-1:0]           in_opcode,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] out_support_x,
  input logic signed [COORD_W-1:0] out_support_y,
  input logic [SIDX_W-1:0]         out_support_index,
  input logic signed [COORD_W-1:0] out_centre_x,
  input logic signed [COORD_W-1:0] out_centre_y,
  input logic [STAT_W-1:0]         out_status
);

  logic                               query_fire;
  logic                               other_fire;
  logic                               out_stall;
  logic                               out_empty;
  logic [4*COORD_W+SIDX_W-1:0]        out_fields;
  logic [4*COORD_W+SIDX_W+STAT_W-1:0] out_word;

  // Gather request strobes and result fields
  assign query_fire = in_valid && in_ready && (in_opcode == OP_QUERY);
  assign other_fire = in_valid && in_ready && (in_opcode != OP_QUERY);
  assign out_stall  = out_valid && !out_ready;
  assign out_empty  = out_valid && (out_status == STAT_EMPTY);
  assign out_fields = {out_support_x, out_support_y, out_support_index,
                       out_centre_x, out_centre_y};
  assign out_word   = {out_fields, out_status};

  // Hold a stalled result
  `CHK_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word), "held result moved")

  // An empty-store result carries zero fields
  `CHK_SAME(a_empty_zero, clk, rst_n, out_empty, out_fields == '0, "empty result not zero")

  // A query request occupies the core
  `CHK_NEXT(a_query_busy, clk, rst_n, query_fire, !in_ready, "ready right after query")

  // Other requests leave the core ready in the next cycle
  `CHK_NEXT(a_other_fast, clk, rst_n, other_fire, in_ready, "ready dropped after request")

  // A new result appears only at the end of a query
  `CHK_SAME(a_result_src, clk, rst_n, $rose(out_valid), $past(!in_ready), "result while idle")

endmodule

bind polygon_support_point_core psp_chk u_psp_chk (.*);
